// ===== hdl/sexl_pkg.sv =====
// ----------------------------------------------------------------------------
// sexl_pkg
// Shared types and constants for the s-expression token lexer.
// ----------------------------------------------------------------------------
package sexl_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MAX_EVENTS      = 3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    KIND_OPEN   = 3'd0,
    KIND_CLOSE  = 3'd1,
    KIND_NUM    = 3'd2,
    KIND_SYMC   = 3'd3,
    KIND_SYMEND = 3'd4,
    KIND_EOI    = 3'd5,
    KIND_ERR    = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_SYM   = 4'b0010,
    MODE_NUM   = 4'b0100,
    MODE_MINUS = 4'b1000
  } mode_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] sym_char;
  } lex_evt_t;

  // all events caused by one text byte
  typedef struct packed {
    logic [1:0]                     cnt;
    lex_evt_t [MAX_EVENTS-1:0]      evt;
    logic [31:0]                    value;
    logic                           overflow;
  } evt_grp_t;

endpackage

// ===== hdl/sexpr_token_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// sexpr_token_lexer_unit
// S-expression tokenizer: one text byte in, token events out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one text byte per transaction (valid/ready), zero ends the input.
//   out_* : one token event per transaction (valid/ready); out_last marks the
//           final event caused by a byte. A byte causes zero to three events.
//   Throughput: one byte per cycle while the event queue has room; the output
//   side moves one event per cycle while the receiver is ready, so bytes
//   causing several events drain one event at a time and the queue of
//   QUEUE_DEPTH event groups absorbs such bursts.
//   Path: with the queue and output hold register empty, a taken byte's
//   event group is written into the queue at the accepting edge and then
//   loaded into the output hold register, which drives the out_* ports.
//   Reset (rst_n low, synchronous) empties the queue, drops any pending
//   event and returns the lexer to idle with no open token.
//   When the receiver stalls, the current event holds on the out_* ports;
//   bytes keep being taken until the queue fills, then in_ready drops.
// ----------------------------------------------------------------------------
module sexpr_token_lexer_unit import sexl_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_sym_char,
  output logic [31:0] out_value,
  output logic        out_overflow,
  output logic        out_last
);

  logic     push, full, pop, q_valid;
  evt_grp_t push_data, q_data;

  sexl_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte_req (in_byte_req),
    .q_full      (full),
    .q_push      (push),
    .q_data      (push_data)
  );

  sexl_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  sexl_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_sym_char (out_sym_char),
    .out_value    (out_value),
    .out_overflow (out_overflow),
    .out_last     (out_last)
  );

endmodule

// ===== hdl/sexl_front.sv =====
// ----------------------------------------------------------------------------
// sexl_front
// Classifies each text byte, tracks the token state and forms the group of
// events the byte causes.
// ----------------------------------------------------------------------------
module sexl_front import sexl_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_req,
  input  logic       q_full,
  output logic       q_push,
  output evt_grp_t   q_data
);

  localparam int EXT_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

  mode_t                  mode_r, mode_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic                   wrap_r, wrap_nxt;

  logic                   is_dig, is_ws, is_symc;
  logic [3:0]             digit;
  logic [VALUE_WIDTH+3:0] acc;
  logic                   acc_ovf;
  logic [EXT_W-1:0]       ext;
  logic [31:0]            num_val;
  evt_grp_t               grp;
  logic [1:0]             n;
  logic                   run_idle, run_sym;
  logic                   accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [7:0] c;
    c       = in_byte_req;
    is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
    is_ws   = (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB);
    is_symc = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
              c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F || c == 8'h25 ||
              c == 8'h3C || c == 8'h3D || c == 8'h3E || c == 8'h7E || c == 8'h21 ||
              c == 8'h24 || c == 8'h40 || c == 8'h26 || c == 8'h7C || c == 8'h5E ||
              c == 8'h3F || c == 8'h3A || c == 8'h5F;
    digit   = c[3:0];
  end

  // magnitude*10 + digit as shifts and adds, carries above the width flag a wrap
  assign acc     = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1)
                 + (VALUE_WIDTH+4)'(digit);
  assign acc_ovf = |acc[VALUE_WIDTH+3:VALUE_WIDTH];

  assign ext     = neg_r ? (EXT_W'(0) - EXT_W'(mag_r)) : EXT_W'(mag_r);
  assign num_val = ext[31:0];

  always_comb begin
    grp      = '0;
    n        = 2'd0;
    mode_nxt = mode_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    wrap_nxt = wrap_r;
    run_idle = 1'b0;
    run_sym  = 1'b0;

    case (mode_r)
      MODE_SYM: begin
        run_sym = 1'b1;
      end
      MODE_NUM: begin
        if (is_dig) begin
          mag_nxt  = acc[VALUE_WIDTH-1:0];
          wrap_nxt = wrap_r | acc_ovf;
        end else begin
          grp.evt[n].kind = KIND_NUM;
          grp.value       = num_val;
          grp.overflow    = wrap_r;
          n               = n + 2'd1;
          mag_nxt         = '0;
          neg_nxt         = 1'b0;
          wrap_nxt        = 1'b0;
          run_idle        = 1'b1;
        end
      end
      MODE_MINUS: begin
        if (is_dig) begin
          mag_nxt  = VALUE_WIDTH'(digit);
          wrap_nxt = 1'b0;
          neg_nxt  = 1'b1;
          mode_nxt = MODE_NUM;
        end else begin
          grp.evt[n].kind     = KIND_SYMC;
          grp.evt[n].sym_char = CH_MINUS;
          n                   = n + 2'd1;
          run_sym             = 1'b1;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    if (run_sym) begin
      if (is_symc) begin
        grp.evt[n].kind     = KIND_SYMC;
        grp.evt[n].sym_char = in_byte_req;
        n                   = n + 2'd1;
        mode_nxt            = MODE_SYM;
      end else begin
        grp.evt[n].kind = KIND_SYMEND;
        n               = n + 2'd1;
        run_idle        = 1'b1;
      end
    end

    if (run_idle) begin
      mode_nxt = MODE_IDLE;
      if (is_ws) begin
        mode_nxt = MODE_IDLE;
      end else if (in_byte_req == CH_LPAR) begin
        grp.evt[n].kind = KIND_OPEN;
        n               = n + 2'd1;
      end else if (in_byte_req == CH_RPAR) begin
        grp.evt[n].kind = KIND_CLOSE;
        n               = n + 2'd1;
      end else if (in_byte_req == CH_NUL) begin
        grp.evt[n].kind = KIND_EOI;
        n               = n + 2'd1;
      end else if (is_dig) begin
        mag_nxt  = VALUE_WIDTH'(digit);
        wrap_nxt = 1'b0;
        neg_nxt  = 1'b0;
        mode_nxt = MODE_NUM;
      end else if (in_byte_req == CH_MINUS) begin
        mode_nxt = MODE_MINUS;
      end else if (is_symc) begin
        grp.evt[n].kind     = KIND_SYMC;
        grp.evt[n].sym_char = in_byte_req;
        n                   = n + 2'd1;
        mode_nxt            = MODE_SYM;
      end else begin
        grp.evt[n].kind = KIND_ERR;
        n               = n + 2'd1;
      end
    end

    grp.cnt = n;
  end

  assign q_push = accept && (n != 2'd0);
  assign q_data = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      mag_r  <= '0;
      neg_r  <= 1'b0;
      wrap_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
      wrap_r <= wrap_nxt;
    end
  end

endmodule

// ===== hdl/sexl_queue.sv =====
// ----------------------------------------------------------------------------
// sexl_queue
// Small first-in first-out queue of event groups between front and back.
// ----------------------------------------------------------------------------
module sexl_queue import sexl_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  evt_grp_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output evt_grp_t data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  evt_grp_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign data    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/sexl_back.sv =====
// ----------------------------------------------------------------------------
// sexl_back
// Holds one event group and hands its events to the output one at a time.
// ----------------------------------------------------------------------------
module sexl_back import sexl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  evt_grp_t    q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_sym_char,
  output logic [31:0] out_value,
  output logic        out_overflow,
  output logic        out_last
);

  evt_grp_t   cur_r;
  logic       cur_vld_r;
  logic [1:0] idx_r;
  logic       is_last, take, need;
  lex_evt_t   evt;
  logic       is_num;

  assign is_last = (idx_r == (cur_r.cnt - 2'd1));
  assign take    = cur_vld_r && out_ready;
  assign need    = !cur_vld_r || (take && is_last);
  assign q_pop   = need && q_valid;

  assign evt          = cur_r.evt[idx_r];
  assign is_num       = (evt.kind == KIND_NUM);
  assign out_valid    = cur_vld_r;
  assign out_kind     = evt.kind;
  assign out_sym_char = evt.sym_char;
  assign out_value    = is_num ? cur_r.value : 32'd0;
  assign out_overflow = is_num && cur_r.overflow;
  assign out_last     = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else if (need) begin
      cur_vld_r <= q_valid;
      idx_r     <= 2'd0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

endmodule

// ===== hdl/sexl_checker.sv =====
// ----------------------------------------------------------------------------
// sexl_checker
// Port-level checks on the token event stream of the lexer.
// ----------------------------------------------------------------------------
module sexl_checker import sexl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_sym_char,
  input logic [31:0] out_value,
  input logic        out_overflow,
  input logic        out_last
);

  // only symbol characters carry a byte
  a_symchar_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_SYMC) |-> out_sym_char == 8'd0)
    else $error("sym_char set on a non-symbol event");

  // only numbers carry a value and overflow flag
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_NUM) |-> (out_value == 32'd0) && !out_overflow)
    else $error("value or overflow set on a non-number event");

  // end of input and error always close the events of their byte
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == KIND_EOI) || (out_kind == KIND_ERR)) |-> out_last)
    else $error("end of input or error not marked last");

  // a stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_value) && $stable(out_last))
    else $error("stalled output event changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sexpr_token_lexer_unit sexl_checker u_sexl_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Token lexer check: a short table of text bytes, then random token streams
// under several idle/stall patterns, with every token event compared against
// a behavioral lexer kept in the bench, or for typed rows against the table.
// ----------------------------------------------------------------------------
module tb_top import sexl_pkg::*; ();

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 16;
  localparam int DIR_ROWS = 24;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  sym_char;
    logic [31:0] value;
    logic        overflow;
    logic        last;
  } token_evt_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    kind_t      kind;
  } dir_row_t;

  // kind is only looked at on typed rows
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{CH_NUL,   1'b1, KIND_EOI},
    '{CH_LPAR,  1'b1, KIND_OPEN},
    '{CH_RPAR,  1'b1, KIND_CLOSE},
    '{".",      1'b1, KIND_ERR},
    '{8'hFF,    1'b1, KIND_ERR},
    '{"2",      1'b0, KIND_OPEN},
    '{"1",      1'b0, KIND_OPEN},
    '{"4",      1'b0, KIND_OPEN},
    '{"7",      1'b0, KIND_OPEN},
    '{"4",      1'b0, KIND_OPEN},
    '{"8",      1'b0, KIND_OPEN},
    '{"3",      1'b0, KIND_OPEN},
    '{"6",      1'b0, KIND_OPEN},
    '{"4",      1'b0, KIND_OPEN},
    '{"8",      1'b0, KIND_OPEN},
    '{CH_RPAR,  1'b0, KIND_OPEN},
    '{CH_MINUS, 1'b0, KIND_OPEN},
    '{CH_ZERO,  1'b0, KIND_OPEN},
    '{CH_NUL,   1'b0, KIND_OPEN},
    '{CH_MINUS, 1'b0, KIND_OPEN},
    '{CH_LPAR,  1'b0, KIND_OPEN},
    '{"z",      1'b0, KIND_OPEN},
    '{CH_MINUS, 1'b0, KIND_OPEN},
    '{CH_TAB,   1'b0, KIND_OPEN}
  };

  string sym_punct = "+-*/%<=>~!$@&|^?:_";

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_req = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_sym_char;
  logic [31:0] out_value;
  logic        out_overflow;
  logic        out_last;

  // bench-side lexer state
  mode_t       lex_mode = MODE_IDLE;
  logic [31:0] num_mag = '0;
  logic        num_neg = 1'b0;
  logic        num_wrap = 1'b0;
  token_evt_t  tok_buf [3];
  int          tok_cnt;
  token_evt_t  pending_tokens [$];

  logic        row_typed = 1'b0;
  kind_t       row_kind = KIND_OPEN;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          rx_hold_req = 1'b0;
  int          hold_left = 0;
  int          bytes_sent = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  token_evt_t  got, want;

  sexpr_token_lexer_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte_req  (in_byte_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_sym_char (out_sym_char),
    .out_value    (out_value),
    .out_overflow (out_overflow),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_LF || c == CH_TAB;
  endfunction

  function automatic bit is_sym_char(logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "%", "<", "=", ">", "~", "!",
      "$", "@", "&", "|", "^", "?", ":", "_": return 1'b1;
      default: return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endcase
  endfunction

  task automatic add_token(kind_t k, logic [7:0] ch, logic [31:0] v, logic ovf);
    tok_buf[tok_cnt] = '{k, ch, v, ovf, 1'b0};
    tok_cnt++;
  endtask

  task automatic add_digit(logic [7:0] c);
    logic [35:0] acc;
    acc = num_mag * 36'd10 + (c - CH_ZERO);
    if (acc[35:32] != 4'd0) num_wrap = 1'b1;
    num_mag = acc[31:0];
  endtask

  task automatic start_number(logic [7:0] c, logic neg);
    num_mag = '0;
    num_wrap = 1'b0;
    num_neg = neg;
    add_digit(c);
    lex_mode = MODE_NUM;
  endtask

  task automatic lex_from_idle(logic [7:0] c);
    lex_mode = MODE_IDLE;
    if (is_blank(c)) return;
    if (c == CH_LPAR) add_token(KIND_OPEN, 8'h00, 32'h0, 1'b0);
    else if (c == CH_RPAR) add_token(KIND_CLOSE, 8'h00, 32'h0, 1'b0);
    else if (c == CH_NUL) add_token(KIND_EOI, 8'h00, 32'h0, 1'b0);
    else if (is_digit(c)) start_number(c, 1'b0);
    else if (c == CH_MINUS) lex_mode = MODE_MINUS;
    else if (is_sym_char(c)) begin
      add_token(KIND_SYMC, c, 32'h0, 1'b0);
      lex_mode = MODE_SYM;
    end else add_token(KIND_ERR, 8'h00, 32'h0, 1'b0);
  endtask

  task automatic lex_in_symbol(logic [7:0] c);
    if (is_sym_char(c)) begin
      add_token(KIND_SYMC, c, 32'h0, 1'b0);
      lex_mode = MODE_SYM;
    end else begin
      add_token(KIND_SYMEND, 8'h00, 32'h0, 1'b0);
      lex_from_idle(c);
    end
  endtask

  // tokens caused by one text byte land in tok_buf[0 .. tok_cnt-1]
  task automatic lex_byte(logic [7:0] c);
    tok_cnt = 0;
    case (lex_mode)
      MODE_SYM: lex_in_symbol(c);
      MODE_NUM: begin
        if (is_digit(c)) add_digit(c);
        else begin
          add_token(KIND_NUM, 8'h00, num_neg ? 32'd0 - num_mag : num_mag, num_wrap);
          num_mag = '0;
          num_neg = 1'b0;
          num_wrap = 1'b0;
          lex_from_idle(c);
        end
      end
      MODE_MINUS: begin
        if (is_digit(c)) start_number(c, 1'b1);
        else begin
          add_token(KIND_SYMC, CH_MINUS, 32'h0, 1'b0);
          lex_in_symbol(c);
        end
      end
      default: lex_from_idle(c);
    endcase
  endtask

  // scoreboard: predict on accepted bytes, compare accepted tokens
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      lex_byte(in_byte_req);
      if (row_typed) pending_tokens.push_back('{row_kind, 8'h00, 32'h0, 1'b0, 1'b1});
      else begin
        for (int i = 0; i < tok_cnt; i++) begin
          tok_buf[i].last = (i == tok_cnt - 1);
          pending_tokens.push_back(tok_buf[i]);
        end
      end
    end
    if (rst_n && out_valid && out_ready) begin
      got = '{kind_t'(out_kind), out_sym_char, out_value, out_overflow, out_last};
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d sym %h value %h ovf %b last %b",
                   got.kind, got.sym_char, got.value, got.overflow, got.last);
      end else begin
        want = pending_tokens.pop_front();
        if (got.kind !== want.kind || got.sym_char !== want.sym_char ||
            got.value !== want.value || got.overflow !== want.overflow ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("token mismatch: expected kind %0d sym %h value %h ovf %b last %b, %s",
                     want.kind, want.sym_char, want.value, want.overflow, want.last,
                     $sformatf("got kind %0d sym %h value %h ovf %b last %b",
                               got.kind, got.sym_char, got.value, got.overflow, got.last));
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    bit hold_served;
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_req <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // one token's worth of text, mostly well formed, some noise
  task automatic send_random_token();
    int pick, len;
    pick = $urandom_range(99);
    if (pick < 30) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
      if ($urandom_range(2) == 0) send_byte(CH_MINUS);
      repeat (len) send_byte(8'(CH_ZERO + $urandom_range(9)));
    end else if (pick < 50) begin
      len = $urandom_range(1, 5);
      repeat (len) begin
        case ($urandom_range(2))
          0: send_byte(8'("a" + $urandom_range(25)));
          1: send_byte(8'("A" + $urandom_range(25)));
          default: send_byte(sym_punct[$urandom_range(sym_punct.len() - 1)]);
        endcase
      end
    end else if (pick < 62) send_byte($urandom_range(1) ? CH_LPAR : CH_RPAR);
    else if (pick < 75) begin
      case ($urandom_range(2))
        0: send_byte(CH_SPACE);
        1: send_byte(CH_LF);
        default: send_byte(CH_TAB);
      endcase
    end
    else if (pick < 82) send_byte(CH_MINUS);
    else if (pick < 88) send_byte(CH_NUL);
    else send_byte(8'($urandom_range(255)));
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    while (bytes_sent < target) send_random_token();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row_typed <= dir_rows[i].typed;
      row_kind <= dir_rows[i].kind;
      send_byte(dir_rows[i].ch);
    end
    row_typed <= 1'b0;

    run_phase(0, 0, 25);
    run_phase(87, 0, 25);
    run_phase(0, 87, 25);
    // receiver holds off while bytes keep coming, so the queue fills
    rx_hold_req = 1'b1;
    run_phase(0, 0, 15);
    run_phase(9, 9, 15);

    in_valid <= 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_tokens.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sexl_pkg.sv
hdl/sexl_front.sv
hdl/sexl_queue.sv
hdl/sexl_back.sv
hdl/sexpr_token_lexer_unit.sv
hdl/sexl_checker.sv
verif/tb_top.sv
